### src/assert_macros.svh
// Assertion macros shared by the layer normalization RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LN_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LN_ASSERT(lbl, clk, rst_n, prop, msg)
`define LN_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### src/lnorm_pkg.sv
// Shared types and constants of the layer normalization block
`default_nettype none
package lnorm_pkg;
    localparam int MAX_LEN_DEF = 64;
    localparam int DATA_W      = 16;
    localparam int EPS_W       = 16;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int SUM_W       = 24;
    localparam int SQ_W        = 40;
    localparam int VE_W        = 36;
    localparam int RAD_W       = 52;
    localparam int ROOT_W      = 26;
    localparam int DIV_NW      = 48;
    localparam int DIV_DW      = 26;
    localparam int Q_W         = 40;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] scale;
        logic signed [DATA_W-1:0] shift;
    } t_elem;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
        t_elem            data;
    } t_wr;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             ovf;
        logic             bank;
    } t_job;

    typedef struct packed {
        logic signed [DATA_W-1:0] normalized;
        logic                     final_element;
        logic                     truncated;
    } t_res;

    typedef struct packed {
        logic busy;
        logic bank;
        logic div_busy;
        logic sqrt_busy;
    } t_bk_stat;
endpackage
`default_nettype wire

### src/lnorm_front.sv
// Front end: accepts items, writes the store and closes vectors into jobs
`default_nettype none
module lnorm_front #(
    parameter int MAX_LEN = 64
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           push,
    output logic                          full,
    input  wire  [lnorm_pkg::DATA_W-1:0]  i_sample,
    input  wire  [lnorm_pkg::DATA_W-1:0]  i_scale,
    input  wire  [lnorm_pkg::DATA_W-1:0]  i_shift,
    input  wire                           i_vector_end,
    input  wire                           i_jq_full,
    output logic                          o_jq_push,
    output lnorm_pkg::t_job               o_job,
    output lnorm_pkg::t_wr                o_wr
);
    import lnorm_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_bank, n_bank;
    logic             accept;
    logic             store;

    assign full   = i_jq_full;
    assign accept = push && !i_jq_full;
    assign store  = r_count < CNT_W'(MAX_LEN);

    // Store write port
    always_comb begin
        o_wr.en          = accept && store;
        o_wr.bank        = r_bank;
        o_wr.idx         = r_count[IDX_W-1:0];
        o_wr.data.sample = i_sample;
        o_wr.data.scale  = i_scale;
        o_wr.data.shift  = i_shift;
    end

    // Count elements, flag drops, close the vector on its end marker
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_bank      = r_bank;
        o_jq_push   = 1'b0;
        o_job.count = r_count + CNT_W'(store);
        o_job.ovf   = r_ovf || !store;
        o_job.bank  = r_bank;
        if (accept) begin
            if (i_vector_end) begin
                o_jq_push = 1'b1;
                n_count   = '0;
                n_ovf     = 1'b0;
                n_bank    = !r_bank;
            end else begin
                n_count = r_count + CNT_W'(store);
                n_ovf   = r_ovf || !store;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_bank  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_bank  <= n_bank;
        end
    end
endmodule
`default_nettype wire

### src/lnorm_jobq.sv
// Two-entry job queue between front end and back end
`default_nettype none
module lnorm_jobq (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lnorm_pkg::t_job  i_job,
    input  wire              i_pop,
    output lnorm_pkg::t_job  o_job,
    output logic             o_full,
    output logic             o_empty,
    output logic [1:0]       o_cnt
);
    import lnorm_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cnt   = r_cnt;
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Hold job entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

### src/lnorm_div.sv
// Shared restoring divider, one quotient bit per cycle
`default_nettype none
module lnorm_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [lnorm_pkg::DIV_NW-1:0] i_num,
    input  wire  [lnorm_pkg::DIV_DW-1:0] i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [lnorm_pkg::DIV_NW-1:0] o_quo
);
    import lnorm_pkg::*;
    localparam int STEP_W = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_num, r_quo;
    logic [DIV_DW-1:0] r_den, r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_active, r_done;
    logic [DIV_DW:0]   trial, diff;
    logic              ge;

    assign trial  = {r_rem, r_num[DIV_NW-1]};
    assign diff   = trial - {1'b0, r_den};
    assign ge     = trial >= {1'b0, r_den};
    assign o_busy = r_active;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    // Datapath: shift in one numerator bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_active) begin
            r_num <= {r_num[DIV_NW-2:0], 1'b0};
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_step   <= '0;
            end else if (r_active) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_NW - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### src/lnorm_sqrt.sv
// Integer square root, one root bit per cycle
`default_nettype none
module lnorm_sqrt (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [lnorm_pkg::RAD_W-1:0]  i_rad,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [lnorm_pkg::ROOT_W-1:0] o_root
);
    import lnorm_pkg::*;
    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic              r_active, r_done;
    logic [REM_W-1:0]  shifted, trial;
    logic              ge;

    assign shifted = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign ge      = shifted >= trial;
    assign o_busy  = r_active;
    assign o_done  = r_done;
    assign o_root  = r_root;

    // Datapath: bring down two radicand bits, try the next root bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_active) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? shifted - trial : shifted;
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_step   <= '0;
            end else if (r_active) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### src/lnorm_back.sv
// Back end: element store, statistics passes, normalization and result queue
`default_nettype none
module lnorm_back #(
    parameter int MAX_LEN = 64
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  lnorm_pkg::t_wr                i_wr,
    input  lnorm_pkg::t_job               i_job,
    input  wire                           i_job_valid,
    output logic                          o_job_pop,
    input  wire  [lnorm_pkg::EPS_W-1:0]   i_eps,
    input  wire                           pop,
    output logic                          empty,
    output logic [lnorm_pkg::DATA_W-1:0]  o_normalized,
    output logic                          o_final_element,
    output logic                          o_truncated,
    output lnorm_pkg::t_bk_stat           o_stat
);
    import lnorm_pkg::*;
    localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DEPTH = 2 << AW;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SUM  = 9'b000000010,
        ST_MDIV = 9'b000000100,
        ST_VAR  = 9'b000001000,
        ST_VDIV = 9'b000010000,
        ST_ROOT = 9'b000100000,
        ST_NORM = 9'b001000000,
        ST_QDIV = 9'b010000000,
        ST_EMIT = 9'b100000000
    } t_state;

    t_elem r_mem [DEPTH];
    t_elem r_rd;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic [1:0]                 r_ph, n_ph;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [DATA_W-1:0]   r_mean, n_mean;
    logic [SQ_W-1:0]            r_sq, n_sq;
    logic [2*DATA_W+1:0]        r_dsq, n_dsq;
    logic [SQ_W-1:0]            r_var, n_var;
    logic [ROOT_W-1:0]          r_root, n_root;
    logic signed [2*DATA_W:0]   r_prod, n_prod;
    logic signed [Q_W-1:0]      r_q, n_q;

    logic                       last;
    logic signed [DATA_W:0]     dev;
    logic signed [2*DATA_W+1:0] dev_sq;
    logic signed [2*DATA_W:0]   prod;
    logic [SUM_W-1:0]           sum_mag;
    logic [2*DATA_W:0]          prod_mag;
    logic [DATA_W-1:0]          mean_mag;
    logic [Q_W-1:0]             q_mag;
    logic [VE_W-1:0]            var_eps;
    logic signed [Q_W:0]        res_wide;
    logic signed [DATA_W-1:0]   res_sat;

    logic                       div_start, div_busy, div_done;
    logic [DIV_NW-1:0]          div_num, div_quo;
    logic [DIV_DW-1:0]          div_den;
    logic                       sq_start, sq_busy, sq_done;
    logic [ROOT_W-1:0]          sq_root;

    t_res                       r_oq [2];
    logic                       r_owp, r_orp;
    logic [1:0]                 r_ocnt;
    logic                       oq_push, oq_pop;
    t_res                       res;

    // Element store: front end writes one bank, this side reads the other
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[AW-1:0]}] <= i_wr.data;
        end
        r_rd <= r_mem[{i_job.bank, r_idx[AW-1:0]}];
    end

    // Element arithmetic
    always_comb begin
        last     = r_idx == i_job.count - 1'b1;
        dev      = {r_rd.sample[DATA_W-1], r_rd.sample} - {r_mean[DATA_W-1], r_mean};
        dev_sq   = dev * dev;
        prod     = r_rd.scale * dev;
        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        prod_mag = r_prod[2*DATA_W] ? (2*DATA_W+1)'(-r_prod) : (2*DATA_W+1)'(r_prod);
        mean_mag = div_quo[DATA_W-1:0];
        q_mag    = div_quo[Q_W-1:0];
        var_eps  = r_var[VE_W-1:0] + VE_W'(i_eps);
        res_wide = (Q_W+1)'(r_q) + (Q_W+1)'(r_rd.shift);
        if (res_wide > (Q_W+1)'(32767)) begin
            res_sat = 16'sh7fff;
        end else if (res_wide < -(Q_W+1)'(32768)) begin
            res_sat = 16'sh8000;
        end else begin
            res_sat = res_wide[DATA_W-1:0];
        end
        res.normalized    = res_sat;
        res.final_element = last;
        res.truncated     = i_job.ovf;
    end

    // Divider operands by pass
    always_comb begin
        div_num = DIV_NW'(r_sq);
        div_den = DIV_DW'(i_job.count);
        if (r_state == ST_MDIV) begin
            div_num = DIV_NW'(sum_mag) + DIV_NW'(i_job.count >> 1);
        end else if (r_state == ST_QDIV) begin
            div_num = DIV_NW'({prod_mag, 4'b0000}) + DIV_NW'(r_root >> 1);
            div_den = DIV_DW'(r_root);
        end
    end

    // Sequencer over the passes
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_ph      = r_ph;
        n_sum     = r_sum;
        n_mean    = r_mean;
        n_sq      = r_sq;
        n_dsq     = r_dsq;
        n_var     = r_var;
        n_root    = r_root;
        n_prod    = r_prod;
        n_q       = r_q;
        div_start = 1'b0;
        sq_start  = 1'b0;
        oq_push   = 1'b0;
        o_job_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = ST_SUM;
                    n_idx   = '0;
                    n_ph    = 2'd0;
                    n_sum   = '0;
                end
            end
            ST_SUM: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_sum = r_sum + SUM_W'(r_rd.sample);
                    n_ph  = 2'd0;
                    if (last) begin
                        n_state = ST_MDIV;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_MDIV: begin
                if (r_ph == 2'd0) begin
                    div_start = 1'b1;
                    n_ph      = 2'd1;
                end else if (div_done) begin
                    n_mean  = r_sum[SUM_W-1] ? -mean_mag : mean_mag;
                    n_state = ST_VAR;
                    n_idx   = '0;
                    n_ph    = 2'd0;
                    n_sq    = '0;
                end
            end
            ST_VAR: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else if (r_ph == 2'd1) begin
                    n_dsq = dev_sq;
                    n_ph  = 2'd2;
                end else begin
                    n_sq = r_sq + SQ_W'(r_dsq);
                    n_ph = 2'd0;
                    if (last) begin
                        n_state = ST_VDIV;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_VDIV: begin
                if (r_ph == 2'd0) begin
                    div_start = 1'b1;
                    n_ph      = 2'd1;
                end else if (div_done) begin
                    n_var   = div_quo[SQ_W-1:0];
                    n_state = ST_ROOT;
                    n_ph    = 2'd0;
                end
            end
            ST_ROOT: begin
                if (r_ph == 2'd0) begin
                    sq_start = 1'b1;
                    n_ph     = 2'd1;
                end else if (sq_done) begin
                    n_root  = sq_root;
                    n_state = ST_NORM;
                    n_idx   = '0;
                    n_ph    = 2'd0;
                end
            end
            ST_NORM: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else if (r_ph == 2'd1) begin
                    n_prod = prod;
                    n_ph   = 2'd2;
                end else begin
                    n_ph = 2'd0;
                    if (r_root == '0) begin
                        n_q     = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_QDIV;
                    end
                end
            end
            ST_QDIV: begin
                if (r_ph == 2'd0) begin
                    div_start = 1'b1;
                    n_ph      = 2'd1;
                end else if (div_done) begin
                    n_q     = r_prod[2*DATA_W] ? -$signed(q_mag) : $signed(q_mag);
                    n_state = ST_EMIT;
                    n_ph    = 2'd0;
                end
            end
            ST_EMIT: begin
                if (r_ocnt != 2'd2) begin
                    oq_push = 1'b1;
                    if (last) begin
                        o_job_pop = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_NORM;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_ph    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ph    <= n_ph;
        end
    end

    // Pass accumulators and intermediate values
    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_mean <= n_mean;
        r_sq   <= n_sq;
        r_dsq  <= n_dsq;
        r_var  <= n_var;
        r_root <= n_root;
        r_prod <= n_prod;
        r_q    <= n_q;
    end

    lnorm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    lnorm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   ({var_eps, 16'h0000}),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Result queue toward the consumer
    assign oq_pop          = pop && (r_ocnt != 2'd0);
    assign empty           = r_ocnt == 2'd0;
    assign o_normalized    = r_oq[r_orp].normalized;
    assign o_final_element = r_oq[r_orp].final_element;
    assign o_truncated     = r_oq[r_orp].truncated;

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (oq_push) begin
                r_owp <= !r_owp;
            end
            if (oq_pop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + 2'(oq_push) - 2'(oq_pop);
        end
    end

    // Status toward the top level
    always_comb begin
        o_stat.busy      = r_state != ST_IDLE;
        o_stat.bank      = i_job.bank;
        o_stat.div_busy  = div_busy;
        o_stat.sqrt_busy = sq_busy;
    end
endmodule
`default_nettype wire

### src/layer_normalization_top.sv
// Layer normalization: per-vector mean, variance, square root and scaled output
// Loading takes one item per cycle while the job queue is not full, into one of two store banks;
// a vector end queues a job, so the next vector loads while the previous one is worked.
// Work per vector: the statistics passes (sum, mean divide on the shared divider, variance,
// variance divide, square root), then per result a product, a divide by a nonzero root and an emit.
// Synchronous active-low reset clears control; epsilon = 1.
`default_nettype none
`include "assert_macros.svh"
module layer_normalization_top #(
    parameter int MAX_LEN = lnorm_pkg::MAX_LEN_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [lnorm_pkg::EPS_W-1:0]   i_cfg_wdata,
    input  wire                           push,
    output logic                          full,
    input  wire  [lnorm_pkg::DATA_W-1:0]  i_sample,
    input  wire  [lnorm_pkg::DATA_W-1:0]  i_scale,
    input  wire  [lnorm_pkg::DATA_W-1:0]  i_shift,
    input  wire                           i_vector_end,
    input  wire                           pop,
    output logic                          empty,
    output logic [lnorm_pkg::DATA_W-1:0]  o_normalized,
    output logic                          o_final_element,
    output logic                          o_truncated
);
    import lnorm_pkg::*;

    logic [EPS_W-1:0] r_eps;
    t_wr              wr;
    t_job             job_in, job_head;
    logic             jq_push, jq_pop, jq_full, jq_empty;
    logic [1:0]       jq_cnt;
    t_bk_stat         bk_stat;
    logic             units_busy;
    logic             bank_clash;

    // Epsilon register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    lnorm_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .i_scale      (i_scale),
        .i_shift      (i_shift),
        .i_vector_end (i_vector_end),
        .i_jq_full    (jq_full),
        .o_jq_push    (jq_push),
        .o_job        (job_in),
        .o_wr         (wr)
    );

    lnorm_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_job   (job_in),
        .i_pop   (jq_pop),
        .o_job   (job_head),
        .o_full  (jq_full),
        .o_empty (jq_empty),
        .o_cnt   (jq_cnt)
    );

    lnorm_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr),
        .i_job           (job_head),
        .i_job_valid     (!jq_empty),
        .o_job_pop       (jq_pop),
        .i_eps           (r_eps),
        .pop             (pop),
        .empty           (empty),
        .o_normalized    (o_normalized),
        .o_final_element (o_final_element),
        .o_truncated     (o_truncated),
        .o_stat          (bk_stat)
    );

    // Checks
    assign units_busy = bk_stat.div_busy && bk_stat.sqrt_busy;
    assign bank_clash = wr.en && bk_stat.busy && (wr.bank == bk_stat.bank);

    `LN_ASSERT_NEVER(a_jq_level, i_clk, i_rst_n, jq_cnt == 2'd3, "job queue level out of range")
    `LN_ASSERT_NEVER(a_unit_share, i_clk, i_rst_n, units_busy, "divider and root busy together")
    `LN_ASSERT_NEVER(a_bank_clash, i_clk, i_rst_n, bank_clash, "store write into bank in use")
    `LN_ASSERT(a_pop_job, i_clk, i_rst_n, jq_pop |-> !jq_empty && bk_stat.busy, "job pop while idle")
endmodule
`default_nettype wire
